/* rtl/core/ovn_pkg.sv */
`default_nettype none

package ovn_pkg;

  localparam int SEED_W     = 16;
  localparam int QUO_W      = 16;
  localparam int OCT_W      = 3;
  localparam int NUM_OCT    = 7;
  localparam int WEXP_W     = 5;
  localparam int DIVS_W     = 21;
  localparam int DIVD_W     = DIVS_W + QUO_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int WSH_W      = 2;

  localparam logic [WEXP_W-1:0] WEIGHT_TOP = 5'd18;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_OCTAVE_COUNT = 2'd0;
  localparam cfg_idx_t REG_WEIGHT_SHIFT = 2'd1;

  localparam logic [OCT_W-1:0] OCT_RESET = 3'd6;
  localparam logic [WSH_W-1:0] WSH_RESET = 2'd0;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             clear;
    logic             advance;
    logic [OCT_W-1:0] oct;
  } lane_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/octave_value_noise_1d.sv */
`default_nettype none
// One-dimensional value noise summed over octaves.
// Input channel (in_valid/in_ready) takes seed words into a row store until a
// word with last_seed set arrives; a word that arrives with the store full is
// dropped. Words are accepted back to back while the row loads. The last word
// starts the row: one output word per position, in order, last_result on the
// final one. Each position runs every live octave through one shared 16-step
// restoring divider. A live octave is one below octave_count (octave 0 alone
// when octave_count is 0) whose pitch is nonzero. An octave passes through
// the store read, two multiply steps, the divider start, the divide steps and
// then the accumulate. Each position adds setup, the final weighted divide and
// the output load. in_ready stays low from the last seed until the final
// output word is loaded into the output register. A stalled receiver holds the
// output register; the sequencer waits before loading the next word.
// Configuration (cfg_valid/cfg_ready) is always ready. Reset empties the row,
// drops any pending output word and sets octave_count to 6 and weight_shift
// to 0; the seed store is not cleared.
module octave_value_noise_1d #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  ovn_pkg::cfg_idx_t              cfg_index,
  input  logic [ovn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ovn_pkg::SEED_W-1:0]     seed_value,
  input  logic                           last_seed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ovn_pkg::QUO_W-1:0]      noise_value,
  output logic [$clog2(MAX_SAMPLES)-1:0] position,
  output logic                           last_result
);
  import ovn_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int PROD_W = CNT_W + SEED_W;
  localparam int WSUM_W = DIVS_W;
  localparam int ACC_W  = DIVD_W;

  typedef enum logic [9:0] {
    S_LOAD     = 10'b0000000001,
    S_POS_INIT = 10'b0000000010,
    S_OCT_ADDR = 10'b0000000100,
    S_OCT_MUL1 = 10'b0000001000,
    S_OCT_MUL2 = 10'b0000010000,
    S_OCT_GO   = 10'b0000100000,
    S_OCT_WAIT = 10'b0001000000,
    S_FIN_GO   = 10'b0010000000,
    S_FIN_WAIT = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [OCT_W-1:0]  octave_count;
  logic [WSH_W-1:0]  weight_shift;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  len;
  logic [IDX_W-1:0]  x;
  logic [OCT_W-1:0]  o;
  logic [WEXP_W-1:0] wexp;
  logic [ACC_W-1:0]  acc;
  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] num;
  logic [SEED_W-1:0] mem [MAX_SAMPLES];
  logic [SEED_W-1:0] rd_a;
  logic [SEED_W-1:0] rd_b;

  logic              in_acc;
  logic              has_room;
  logic [CNT_W-1:0]  fill_next;
  logic [OCT_W-1:0]  octs;
  logic [CNT_W-1:0]  pitch;
  logic [CNT_W-1:0]  pmr;
  logic [IDX_W-1:0]  r_sel;
  logic [IDX_W-1:0]  s1_sel;
  logic [CNT_W:0]    s2_sum;
  logic [IDX_W-1:0]  s2;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic              oct_done;
  logic              is_last;
  logic              out_free;
  lane_ctl_t         lane_ctl;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = state == S_LOAD;
  assign in_acc    = in_valid && in_ready;
  assign has_room  = fill < CNT_W'(MAX_SAMPLES);
  assign fill_next = has_room ? fill + CNT_W'(1) : fill;
  assign octs      = (octave_count == '0) ? OCT_W'(1) : octave_count;
  assign pitch     = len >> o;
  assign pmr       = pitch - CNT_W'(r_sel);
  assign s2_sum    = (CNT_W + 1)'(s1_sel) + (CNT_W + 1)'(pitch);
  assign s2        = (s2_sum >= (CNT_W + 1)'(len)) ? IDX_W'(s2_sum - (CNT_W + 1)'(len))
                                                    : IDX_W'(s2_sum);
  assign prod_a    = PROD_W'(pmr) * PROD_W'(rd_a);
  assign prod_b    = PROD_W'(r_sel) * PROD_W'(rd_b);
  assign oct_done  = (o == octs) || (pitch == '0);
  assign is_last   = (CNT_W'(x) + CNT_W'(1)) == len;
  assign out_free  = !out_valid || out_ready;

  assign lane_ctl.clear   = state == S_LOAD;
  assign lane_ctl.advance = (state == S_OCT_WAIT) && div_rsp.done;
  assign lane_ctl.oct     = o;

  assign div_req.start    = (state == S_OCT_GO) || (state == S_FIN_GO);
  assign div_req.dividend = (state == S_FIN_GO) ? acc : DIVD_W'(num);
  assign div_req.divisor  = (state == S_FIN_GO) ? wsum : DIVS_W'(pitch);

  ovn_lanes #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_lanes (
    .clk    (clk),
    .ctl    (lane_ctl),
    .pitch  (pitch),
    .r_sel  (r_sel),
    .s1_sel (s1_sel)
  );

  ovn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      mem[fill[IDX_W-1:0]] <= seed_value;
    end
    rd_a <= mem[s1_sel];
    rd_b <= mem[s2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_RESET;
      weight_shift <= WSH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_W-1:0];
        REG_WEIGHT_SHIFT: weight_shift <= cfg_data[WSH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (in_acc && last_seed) state_next = S_POS_INIT;
      S_POS_INIT: state_next = S_OCT_ADDR;
      S_OCT_ADDR: state_next = oct_done ? S_FIN_GO : S_OCT_MUL1;
      S_OCT_MUL1: state_next = S_OCT_MUL2;
      S_OCT_MUL2: state_next = S_OCT_GO;
      S_OCT_GO:   state_next = S_OCT_WAIT;
      S_OCT_WAIT: if (div_rsp.done) state_next = S_OCT_ADDR;
      S_FIN_GO:   state_next = S_FIN_WAIT;
      S_FIN_WAIT: if (div_rsp.done) state_next = S_EMIT;
      S_EMIT:     if (out_free) state_next = is_last ? S_LOAD : S_POS_INIT;
      default:    state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill <= last_seed ? '0 : fill_next;
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_seed) begin
      len <= fill_next;
      x   <= '0;
    end
    unique case (state)
      S_POS_INIT: begin
        o    <= '0;
        wexp <= WEIGHT_TOP;
        acc  <= '0;
        wsum <= '0;
      end
      S_OCT_MUL1: num <= prod_a;
      S_OCT_MUL2: num <= num + prod_b;
      S_OCT_WAIT: begin
        if (div_rsp.done) begin
          acc  <= acc + (ACC_W'(div_rsp.quotient) << wexp);
          wsum <= wsum + (WSUM_W'(1) << wexp);
          wexp <= (wexp > WEXP_W'(weight_shift)) ? wexp - WEXP_W'(weight_shift) : '0;
          o    <= o + OCT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          noise_value <= div_rsp.quotient;
          position    <= x;
          last_result <= is_last;
          x           <= x + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ovn_div.sv */
`default_nettype none

module ovn_div (
  input  logic              clk,
  input  logic              rst,
  input  ovn_pkg::div_req_t req,
  output ovn_pkg::div_rsp_t rsp
);
  import ovn_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] divisor;
  logic [QUO_W-1:0]  quo;
  logic [DIVS_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(QUO_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[DIVD_W-1:QUO_W];
      quo     <= req.dividend[QUO_W-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

/* rtl/core/ovn_lanes.sv */
`default_nettype none

module ovn_lanes #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  ovn_pkg::lane_ctl_t ctl,
  input  logic [CNT_W-1:0]   pitch,
  output logic [IDX_W-1:0]   r_sel,
  output logic [IDX_W-1:0]   s1_sel
);
  import ovn_pkg::*;

  logic [IDX_W-1:0] r  [NUM_OCT];
  logic [IDX_W-1:0] s1 [NUM_OCT];
  logic [OCT_W-1:0] sel;
  logic             wrap;

  assign sel    = (ctl.oct < OCT_W'(NUM_OCT)) ? ctl.oct : '0;
  assign r_sel  = r[sel];
  assign s1_sel = s1[sel];
  assign wrap   = (CNT_W'(r_sel) + CNT_W'(1)) == pitch;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < NUM_OCT; i++) begin
        r[i]  <= '0;
        s1[i] <= '0;
      end
    end else if (ctl.advance) begin
      if (wrap) begin
        r[sel]  <= '0;
        s1[sel] <= IDX_W'(CNT_W'(s1_sel) + pitch);
      end else begin
        r[sel] <= r_sel + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ovn_chk.sv */
`default_nettype none

module ovn_chk (
  input wire        clk,
  input wire        rst,
  input wire        cfg_ready,
  input wire        in_valid,
  input wire        in_ready,
  input wire        last_seed,
  input wire        out_valid,
  input wire        out_ready,
  input wire        last_result,
  input wire [15:0] noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value) && $stable(last_result))
    else $error("output word changed while stalled");

  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_seed |=> !in_ready)
    else $error("input ready right after last seed");

  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_seed |=> in_ready)
    else $error("loading stalled inside a row");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration not ready");

endmodule

bind octave_value_noise_1d ovn_chk u_ovn_chk (
  .clk         (clk),
  .rst         (rst),
  .cfg_ready   (cfg_ready),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_seed   (last_seed),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .last_result (last_result),
  .noise_value (noise_value)
);

`default_nettype wire
